// ===== rtl/assert_macros.svh =====
// assertion macros used by text_console_writer
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/tcw_pkg.sv =====
// constants and types for the text console writer
// no dependencies
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CNT_W   = $clog2(CELLS + 1);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int COL_W   = $clog2(COLUMNS + 1);

   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] ATTR_RESET   = 8'd15;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] code;
   } cell_type;

endpackage

// ===== rtl/text_console_writer.sv =====
// text console writer top level: cell store, cursor and row-walk sequencer
// depends on tcw_pkg and assert_macros.svh
//
//  channel  | handshake             | payload
//  req      | req_valid / req_stall | req_action, req_char_code, req_cell_index
//  rsp      | rsp_valid / rsp_stall | rsp_cell_char, rsp_cell_attr, rsp_cursor_row/col
//  csr      | csr_wr_en             | csr_wr_data (text attribute)
//
// put, newline without scroll: a new beat is taken while the result register drains
// read: registered read of the cell store, the result is loaded from S_FIN
// clear: S_BLANK on all cells; scroll: S_SCROLL copy, S_BLANK on the last row, S_PUTW
// for a pending character, then S_FIN; the single write port walks one cell per cycle
// reset clears cursor and handshake state, loads ATTR_RESET; cells stay undefined until cleared
// a stalled result holds the block before the next result is loaded
`include "assert_macros.svh"

module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attr,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCROLL = 3'd1;
   localparam logic [2:0] S_BLANK  = 3'd2;
   localparam logic [2:0] S_PUTW   = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   localparam int WIDE_W = 11 + tcw_pkg::CNT_W;

   logic [2:0]                state_ff, state_in;
   logic [tcw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tcw_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [7:0]                attr_ff;
   logic [7:0]                char_ff, char_in;
   logic                      put_ff, put_in;
   logic                      rdok_ff, rdok_in;
   logic [tcw_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [tcw_pkg::CNT_W-1:0]  wcnt_ff, wcnt_in;
   logic                      cpv_ff, cpv_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_char_ff, rsp_char_in;
   logic [7:0]                rsp_attr_ff, rsp_attr_in;
   logic [tcw_pkg::ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::COL_W-1:0]  rsp_col_ff, rsp_col_in;

   tcw_pkg::cell_type         mem [tcw_pkg::CELLS];
   tcw_pkg::cell_type         rd_ff;
   tcw_pkg::cell_type         wdata;
   logic                      we, re;
   logic [tcw_pkg::ADDR_W-1:0] waddr, raddr;

   logic                      accept, slot_free, load_rsp, done;
   logic                      is_nl, is_full, is_last, in_range;
   logic [WIDE_W-1:0]         idx_wide;
   logic [tcw_pkg::ADDR_W-1:0] base_next;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_nl     = (req_char_code == tcw_pkg::NEWLINE_CODE);
   assign is_full   = (col_ff >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
   assign is_last   = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
   assign idx_wide  = WIDE_W'(req_cell_index);
   assign in_range  = (idx_wide < WIDE_W'(tcw_pkg::CELLS));
   assign base_next = base_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      char_in     = char_ff;
      put_in      = put_ff;
      rdok_in     = rdok_ff;
      cnt_in      = cnt_ff;
      wcnt_in     = wcnt_ff;
      cpv_in      = 1'b0;
      we          = 1'b0;
      re          = 1'b0;
      waddr       = base_ff;
      raddr       = base_ff;
      wdata.attr  = attr_ff;
      wdata.code  = tcw_pkg::SPACE_CODE;
      done        = 1'b0;
      load_rsp    = 1'b0;
      rsp_char_in = 8'd0;
      rsp_attr_in = 8'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rdok_in = 1'b0;
               unique case (req_action)
                  tcw_pkg::ACT_PUT: begin
                     if (is_nl || is_full) begin
                        col_in = '0;
                        if (!is_last) begin
                           row_in  = row_ff + tcw_pkg::ROW_W'(1);
                           base_in = base_next;
                           if (!is_nl) begin
                              we         = 1'b1;
                              waddr      = base_next;
                              wdata.code = req_char_code;
                              col_in     = tcw_pkg::COL_W'(1);
                           end
                           done = 1'b1;
                        end else begin
                           char_in  = req_char_code;
                           put_in   = !is_nl;
                           cnt_in   = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                           wcnt_in  = '0;
                           state_in = S_SCROLL;
                        end
                     end else begin
                        we         = 1'b1;
                        waddr      = base_ff + tcw_pkg::ADDR_W'(col_ff);
                        wdata.code = req_char_code;
                        col_in     = col_ff + tcw_pkg::COL_W'(1);
                        done       = 1'b1;
                     end
                  end
                  tcw_pkg::ACT_CLEAR: begin
                     put_in   = 1'b0;
                     wcnt_in  = '0;
                     state_in = S_BLANK;
                  end
                  tcw_pkg::ACT_READ: begin
                     if (in_range) begin
                        re       = 1'b1;
                        raddr    = tcw_pkg::ADDR_W'(req_cell_index);
                        rdok_in  = 1'b1;
                        state_in = S_FIN;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
               if (done) begin
                  if (slot_free) begin
                     load_rsp = 1'b1;
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end
         end
         S_SCROLL: begin
            if (cnt_ff != tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
               re     = 1'b1;
               raddr  = cnt_ff[tcw_pkg::ADDR_W-1:0];
               cnt_in = cnt_ff + tcw_pkg::CNT_W'(1);
               cpv_in = 1'b1;
            end
            if (cpv_ff) begin
               we      = 1'b1;
               waddr   = wcnt_ff[tcw_pkg::ADDR_W-1:0];
               wdata   = rd_ff;
               wcnt_in = wcnt_ff + tcw_pkg::CNT_W'(1);
            end else if (cnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            we      = 1'b1;
            waddr   = wcnt_ff[tcw_pkg::ADDR_W-1:0];
            wcnt_in = wcnt_ff + tcw_pkg::CNT_W'(1);
            if (wcnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
               state_in = put_ff ? S_PUTW : S_FIN;
            end
         end
         S_PUTW: begin
            we         = 1'b1;
            waddr      = base_ff;
            wdata.code = char_ff;
            col_in     = tcw_pkg::COL_W'(1);
            put_in     = 1'b0;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               load_rsp    = 1'b1;
               rsp_char_in = rdok_ff ? rd_ff.code : 8'd0;
               rsp_attr_in = rdok_ff ? rd_ff.attr : 8'd0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = row_in;
         rsp_col_in   = col_in;
      end
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         put_ff       <= 1'b0;
         rdok_ff      <= 1'b0;
         cpv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         put_ff       <= put_in;
         rdok_ff      <= rdok_in;
         cpv_ff       <= cpv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      cnt_ff  <= cnt_in;
      wcnt_ff <= wcnt_in;
      if (load_rsp) begin
         rsp_char_ff <= rsp_char_in;
         rsp_attr_ff <= rsp_attr_in;
      end
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_cursor_row = 5'(rsp_row_ff);
   assign rsp_cursor_col = 7'(rsp_col_ff);

   `ASSERT_IMPLIES(a_cursor_bounds, clock, reset, 1'b1,
      (col_ff <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
      (row_ff <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)))
   `ASSERT_IMPLIES(a_copy_behind_read, clock, reset, (state_ff == S_SCROLL) && cpv_ff,
      wcnt_ff < cnt_ff)
   `ASSERT_IMPLIES(a_putw_at_last_row, clock, reset, state_ff == S_PUTW,
      (col_ff == '0) && (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)))
   `ASSERT_NEXT(a_scroll_to_blank, clock, reset,
      (state_ff == S_SCROLL) && !cpv_ff && (cnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELLS)),
      (state_ff == S_BLANK) && (wcnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)))

endmodule
